/* src/lli_pkg.sv */
package lli_pkg;

  localparam int CoordWidth = 16;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int DetWidth   = 2 * CoordWidth + 1;
  localparam int DenWidth   = 2 * DiffWidth + 1;
  localparam int NumWidth   = DetWidth + DiffWidth + 1;
  localparam int NumMag     = NumWidth;
  localparam int QuotWidth  = 33;
  localparam int DenMag     = DenWidth;
  localparam int RemWidth   = DenMag + 1;
  localparam int OutWidth   = 32;

  typedef struct packed {
    logic                  valid;
    logic                  parallel;
    logic                  neg_x;
    logic                  neg_y;
    logic                  big_x;
    logic                  big_y;
    logic [DenMag-1:0]     den;
    logic [NumMag-1:0]     num_x;
    logic [NumMag-1:0]     num_y;
    logic [RemWidth-1:0]   rem_x;
    logic [RemWidth-1:0]   rem_y;
    logic [QuotWidth-1:0]  quo_x;
    logic [QuotWidth-1:0]  quo_y;
  } div_word_t;

endpackage

/* src/lli_front.sv */
module lli_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic                                   in_word_valid,
  input  logic signed [lli_pkg::CoordWidth-1:0]  x1,
  input  logic signed [lli_pkg::CoordWidth-1:0]  y1,
  input  logic signed [lli_pkg::CoordWidth-1:0]  x2,
  input  logic signed [lli_pkg::CoordWidth-1:0]  y2,
  input  logic signed [lli_pkg::CoordWidth-1:0]  x3,
  input  logic signed [lli_pkg::CoordWidth-1:0]  y3,
  input  logic signed [lli_pkg::CoordWidth-1:0]  x4,
  input  logic signed [lli_pkg::CoordWidth-1:0]  y4,
  output lli_pkg::div_word_t                     word_o
);

  localparam int DW = lli_pkg::DiffWidth;
  localparam int TW = lli_pkg::DetWidth;
  localparam int NW = lli_pkg::NumWidth;
  localparam int EW = lli_pkg::DenWidth;

  logic                 v1_r, v2_r, v3_r;
  logic signed [DW-1:0] a_r, b_r, c_r, d_r;
  logic signed [TW-1:0] x1y2_r, y1x2_r, x3y4_r, y3x4_r;
  logic signed [TW-1:0] e_r, f_r;
  logic signed [DW-1:0] a2_r, b2_r, c2_r, d2_r;
  logic signed [NW-1:0] ec_r, af_r, ed_r, bf_r;
  logic signed [EW-1:0] ad_r, bc_r;
  logic signed [NW-1:0] nx, ny;
  logic signed [EW-1:0] den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_word_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r    <= DW'(x1) - DW'(x2);
      b_r    <= DW'(y1) - DW'(y2);
      c_r    <= DW'(x3) - DW'(x4);
      d_r    <= DW'(y3) - DW'(y4);
      x1y2_r <= TW'(x1) * TW'(y2);
      y1x2_r <= TW'(y1) * TW'(x2);
      x3y4_r <= TW'(x3) * TW'(y4);
      y3x4_r <= TW'(y3) * TW'(x4);
      e_r    <= x1y2_r - y1x2_r;
      f_r    <= x3y4_r - y3x4_r;
      a2_r   <= a_r;
      b2_r   <= b_r;
      c2_r   <= c_r;
      d2_r   <= d_r;
      ec_r   <= NW'(e_r) * NW'(c2_r);
      af_r   <= NW'(a2_r) * NW'(f_r);
      ed_r   <= NW'(e_r) * NW'(d2_r);
      bf_r   <= NW'(b2_r) * NW'(f_r);
      ad_r   <= EW'(a2_r) * EW'(d2_r);
      bc_r   <= EW'(b2_r) * EW'(c2_r);
    end
  end

  always_comb begin
    nx = ec_r - af_r;
    ny = ed_r - bf_r;
    den = ad_r - bc_r;
    word_o = '0;
    word_o.valid    = v3_r;
    word_o.parallel = (den == '0);
    word_o.neg_x    = nx[NW-1] ^ den[EW-1];
    word_o.neg_y    = ny[NW-1] ^ den[EW-1];
    word_o.den      = den[EW-1] ? -den : den;
    word_o.num_x    = nx[NW-1] ? -nx : nx;
    word_o.num_y    = ny[NW-1] ? -ny : ny;
  end

endmodule

/* src/lli_cell.sv */
module lli_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  lli_pkg::div_word_t word_i,
  output lli_pkg::div_word_t word_o
);

  localparam int NM = lli_pkg::NumMag;
  localparam int RW = lli_pkg::RemWidth;
  localparam int QW = lli_pkg::QuotWidth;

  lli_pkg::div_word_t word_r, word_nxt;
  logic [RW-1:0] tx, ty;
  logic          gx, gy;

  always_comb begin
    word_nxt = word_i;
    tx = {word_i.rem_x[RW-2:0], word_i.num_x[NM-1]};
    ty = {word_i.rem_y[RW-2:0], word_i.num_y[NM-1]};
    gx = tx >= RW'(word_i.den);
    gy = ty >= RW'(word_i.den);
    word_nxt.rem_x = gx ? tx - RW'(word_i.den) : tx;
    word_nxt.rem_y = gy ? ty - RW'(word_i.den) : ty;
    word_nxt.num_x = {word_i.num_x[NM-2:0], 1'b0};
    word_nxt.num_y = {word_i.num_y[NM-2:0], 1'b0};
    word_nxt.big_x = word_i.big_x | word_i.quo_x[QW-1];
    word_nxt.big_y = word_i.big_y | word_i.quo_y[QW-1];
    word_nxt.quo_x = {word_i.quo_x[QW-2:0], gx};
    word_nxt.quo_y = {word_i.quo_y[QW-2:0], gy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else if (adv) begin
      word_r <= word_nxt;
    end
  end

  assign word_o = word_r;

endmodule

/* src/line_line_intersection.sv */
// Pipeline: registered product stages in lli_front, then one divider cell per numerator bit
// (lli_pkg::NumMag cells), then one output register.
// Throughput: one word per cycle; the whole pipe advances unless the output
// register is full and stalled.
// Reset: synchronous active-low rst_n clears all valid bits; no data is kept.
module line_line_intersection (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_a_start_x,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_a_start_y,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_a_end_x,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_a_end_y,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_b_start_x,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_b_start_y,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_b_end_x,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_b_end_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [lli_pkg::OutWidth-1:0]   out_cross_x,
  output logic signed [lli_pkg::OutWidth-1:0]   out_cross_y,
  output logic                                  out_is_parallel,
  output logic                                  out_saturated
);

  localparam int NC = lli_pkg::NumMag;
  localparam int OW = lli_pkg::OutWidth;
  localparam int QW = lli_pkg::QuotWidth;

  lli_pkg::div_word_t chain [NC+1];
  lli_pkg::div_word_t last;
  logic               adv;
  logic               sx, sy;
  logic [OW-1:0]      qx, qy;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  lli_front u_front (
    .clk, .rst_n, .adv,
    .in_word_valid(in_valid),
    .x1(in_a_start_x), .y1(in_a_start_y), .x2(in_a_end_x), .y2(in_a_end_y),
    .x3(in_b_start_x), .y3(in_b_start_y), .x4(in_b_end_x), .y4(in_b_end_y),
    .word_o(chain[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    lli_cell u_cell (
      .clk, .rst_n, .adv,
      .word_i(chain[i]),
      .word_o(chain[i+1])
    );
  end

  assign last = chain[NC];

  function automatic logic [OW:0] clip(input logic neg, input logic big,
                                       input logic [QW-1:0] q);
    logic [OW:0] r;
    if (neg) begin
      if (big || q > QW'(33'h080000000)) r = {1'b1, 32'h80000000};
      else                               r = {1'b0, OW'(-q)};
    end else begin
      if (big || q > QW'(33'h07FFFFFFF)) r = {1'b1, 32'h7FFFFFFF};
      else                               r = {1'b0, q[OW-1:0]};
    end
    return r;
  endfunction

  always_comb begin
    {sx, qx} = clip(last.neg_x, last.big_x, last.quo_x);
    {sy, qy} = clip(last.neg_y, last.big_y, last.quo_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_is_parallel <= last.parallel;
      out_cross_x     <= last.parallel ? '0 : qx;
      out_cross_y     <= last.parallel ? '0 : qy;
      out_saturated   <= !last.parallel && (sx || sy);
    end
  end

endmodule

/* verif/line_line_intersection_check.sv */
module line_line_intersection_check (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_a_start_x,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_a_start_y,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_a_end_x,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_a_end_y,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_b_start_x,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_b_start_y,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_b_end_x,
  input  logic signed [lli_pkg::CoordWidth-1:0] in_b_end_y,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [lli_pkg::OutWidth-1:0]   out_cross_x,
  input  logic signed [lli_pkg::OutWidth-1:0]   out_cross_y,
  input  logic                                  out_is_parallel,
  input  logic                                  out_saturated,
  output int                                    fail_count,
  output int                                    pending,
  output int                                    n_parallel,
  output int                                    n_clipped
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [lli_pkg::OutWidth-1:0] x;
    logic signed [lli_pkg::OutWidth-1:0] y;
    logic                                par;
    logic                                sat;
  } crossing_t;

  crossing_t crossings[$];

  function automatic logic signed [lli_pkg::OutWidth-1:0] clip_quot(wide_t num, wide_t den,
                                                                    inout logic sat);
    wide_t q;
    q = num / den;
    if (q > wide_t'(64'sh7FFF_FFFF)) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (q < -wide_t'(64'sh8000_0000)) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return q[31:0];
  endfunction

  function automatic crossing_t cross_point(wide_t x1, wide_t y1, wide_t x2, wide_t y2,
                                            wide_t x3, wide_t y3, wide_t x4, wide_t y4);
    crossing_t r;
    wide_t a, b, c, d, e, f, den;
    logic sat;
    a = x1 - x2;
    b = y1 - y2;
    c = x3 - x4;
    d = y3 - y4;
    e = x1 * y2 - y1 * x2;
    f = x3 * y4 - y3 * x4;
    den = a * d - b * c;
    sat = 1'b0;
    r.par = 1'b0;
    if (den == 0) begin
      r.x = '0;
      r.y = '0;
      r.par = 1'b1;
      r.sat = 1'b0;
      return r;
    end
    r.x = clip_quot(e * c - a * f, den, sat);
    r.y = clip_quot(e * d - b * f, den, sat);
    r.sat = sat;
    return r;
  endfunction

  assign pending = crossings.size();

  initial begin
    fail_count = 0;
    n_parallel = 0;
    n_clipped  = 0;
  end

  always @(posedge clk) begin
    crossing_t want;
    if (rst_n && in_valid && !in_stall) begin
      want = cross_point(in_a_start_x, in_a_start_y, in_a_end_x, in_a_end_y,
                         in_b_start_x, in_b_start_y, in_b_end_x, in_b_end_y);
      crossings.push_back(want);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (crossings.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = crossings.pop_front();
        if (want.par) n_parallel++;
        if (want.sat) n_clipped++;
        if (out_cross_x !== want.x) begin
          $error("cross_x: expected %0d, got %0d", want.x, out_cross_x);
          fail_count++;
        end
        if (out_cross_y !== want.y) begin
          $error("cross_y: expected %0d, got %0d", want.y, out_cross_y);
          fail_count++;
        end
        if (out_is_parallel !== want.par) begin
          $error("is_parallel: expected %0b, got %0b", want.par, out_is_parallel);
          fail_count++;
        end
        if (out_saturated !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, out_saturated);
          fail_count++;
        end
      end
    end
  end
endmodule

/* verif/line_line_intersection_test.sv */
module line_line_intersection_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = lli_pkg::CoordWidth;
  localparam int IdleLimit = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [W-1:0] ax0 = '0, ay0 = '0, ax1 = '0, ay1 = '0;
  logic signed [W-1:0] bx0 = '0, by0 = '0, bx1 = '0, by1 = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [lli_pkg::OutWidth-1:0] out_cross_x, out_cross_y;
  logic out_is_parallel, out_saturated;
  int fail_count, pending, n_parallel, n_clipped;
  int idle_cycles = 0;
  int n_sent = 0;
  bit calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_line_intersection dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_a_start_x(ax0), .in_a_start_y(ay0), .in_a_end_x(ax1), .in_a_end_y(ay1),
    .in_b_start_x(bx0), .in_b_start_y(by0), .in_b_end_x(bx1), .in_b_end_y(by1),
    .out_valid, .out_stall, .out_cross_x, .out_cross_y, .out_is_parallel, .out_saturated
  );

  line_line_intersection_check check (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_a_start_x(ax0), .in_a_start_y(ay0), .in_a_end_x(ax1), .in_a_end_y(ay1),
    .in_b_start_x(bx0), .in_b_start_y(by0), .in_b_end_x(bx1), .in_b_end_y(by1),
    .out_valid, .out_stall, .out_cross_x, .out_cross_y, .out_is_parallel, .out_saturated,
    .fail_count, .pending, .n_parallel, .n_clipped
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    @(negedge clk);
    wait (rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_lines(input logic [W-1:0] p0, p1, p2, p3, p4, p5, p6, p7);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    ax0 <= p0; ay0 <= p1; ax1 <= p2; ay1 <= p3;
    bx0 <= p4; by0 <= p5; bx1 <= p6; by1 <= p7;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    n_sent++;
    @(negedge clk);
  endtask

  function automatic logic [W-1:0] near(logic [W-1:0] v, int span);
    return v + W'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic send_random();
    logic [W-1:0] p0, p1, p2, p3, dx, dy;
    int kind, span;
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 3) == 0) ? 32767 : 255;
    p0 = near('0, span); p1 = near('0, span);
    p2 = near('0, span); p3 = near('0, span);
    case (kind)
      0, 1, 2:
        send_lines(W'($urandom), W'($urandom), W'($urandom), W'($urandom),
                   W'($urandom), W'($urandom), W'($urandom), W'($urandom));
      3: begin
        dx = W'($urandom_range(0, 2000));
        dy = W'($urandom_range(0, 2000));
        send_lines(p0, p1, p2, p3, p0 + dx, p1 + dy, p2 + dx, p3 + dy);
      end
      4:
        send_lines(p0, p1, p2, p3, near(p0, 2), near(p1, 2), near(p2, 2), near(p3, 2));
      5:
        send_lines(p0, p1, p0, p1, p2, p3, W'($urandom), W'($urandom));
      6:
        send_lines(W'($urandom), W'($urandom), W'($urandom), W'($urandom),
                   p0, p1, p0, p1);
      default:
        send_lines(p0, p1, p2, p3, near('0, span), near('0, span),
                   near('0, span), near('0, span));
    endcase
  endtask

  localparam logic [W-1:0] MaxC = 16'sh7FFF;
  localparam logic [W-1:0] MinC = 16'sh8000;

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    calm = 1'b1;
    send_lines(16'd0, 16'd0, 16'd160, 16'd160, 16'd0, 16'd160, 16'd160, 16'd0);
    send_lines(MinC, MinC, MaxC, MaxC, MinC, MaxC, MaxC, MinC);
    send_lines(MaxC, MinC, MinC, MaxC, MaxC, MaxC, MinC, MinC);
    send_lines(MinC, MinC, MaxC, MaxC, MinC, -16'sd32767, MaxC, 16'sd32766);
    send_lines(MaxC, MaxC, MinC, MinC, MaxC, 16'sd32766, MinC, -16'sd32767);
    send_lines(MinC, MaxC, MaxC, MinC, -16'sd32767, MaxC, MaxC, -16'sd32767);
    send_lines(MinC, 16'd0, MaxC, 16'd1, MinC, 16'd1, MaxC, 16'd2);
    calm = 1'b0;
    send_lines(16'd0, 16'd0, 16'd16, 16'd16, 16'd32, 16'd0, 16'd48, 16'd16);
    send_lines(16'd5, 16'd7, 16'd5, 16'd7, 16'd1, 16'd2, 16'd3, 16'd4);
    send_lines(16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd9, 16'd9, 16'd9);
    send_lines('0, '0, '0, '0, '0, '0, '0, '0);
    send_lines(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_lines(MaxC, MaxC, MaxC, MaxC, MinC, MinC, MinC, MinC);
    send_lines(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA);
    send_lines(16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0, MaxC, MaxC);
    send_lines(MaxC, 16'd0, MinC, 16'd0, 16'd0, MaxC, 16'd0, MinC);
    send_lines(16'd3, 16'd0, 16'd3, 16'd1, 16'd0, 16'd5, 16'd1, 16'd5);

    // hold until the pipe drains
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    for (int i = 0; i < 1950; i++) begin
      if (i % 300 == 0) calm = ($urandom_range(0, 1) == 1);
      send_random();
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    wait (pending == 0);
    repeat (120) @(posedge clk);
    $display("Sent %0d line pairs; %0d parallel or degenerate, %0d clipped results.",
             n_sent, n_parallel, n_clipped);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* sim.f */
src/lli_pkg.sv
src/lli_front.sv
src/lli_cell.sv
src/line_line_intersection.sv
verif/line_line_intersection_check.sv
verif/line_line_intersection_test.sv
